// ===== sv/asdu_information_object_decoder_assert.svh =====
// Assertion macros shared by the ASDU decoder modules.
// Depends on nothing; included inside the module bodies that check themselves.
`ifndef ASDU_INFORMATION_OBJECT_DECODER_ASSERT_SVH
`define ASDU_INFORMATION_OBJECT_DECODER_ASSERT_SVH

`ifndef SYNTH
// Checked property, switched off while reset is high.
`define ASDU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("asdu decoder assertion failed");
// Checked property that also holds around reset.
`define ASDU_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("asdu decoder reset assertion failed");
`else
`define ASDU_ASSERT(label, clk, rst, prop)
`define ASDU_ASSERT_NR(label, clk, prop)
`endif

`endif

// ===== sv/asdu_pkg.sv =====
// Shared types, codes and type tables of the ASDU information object decoder.
// Depends on nothing; used by asdu_parser, asdu_fifo and the top level.
package asdu_pkg;

   // Record status codes.
   localparam logic [1:0] ST_OBJECT = 2'd0;
   localparam logic [1:0] ST_END    = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   // Value kind codes.
   localparam logic [2:0] KIND_SINGLE = 3'd0;
   localparam logic [2:0] KIND_DOUBLE = 3'd1;
   localparam logic [2:0] KIND_INT16  = 3'd2;
   localparam logic [2:0] KIND_INT32  = 3'd3;
   localparam logic [2:0] KIND_NORM   = 3'd4;
   localparam logic [2:0] KIND_FLOAT  = 3'd5;
   localparam logic [2:0] KIND_BYTE   = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COT_BYTES = 2'd0;
   localparam logic [1:0] CSR_CA_BYTES  = 2'd1;
   localparam logic [1:0] CSR_IOA_BYTES = 2'd2;

   // One result record.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  type_id;
      logic [5:0]  cause;
      logic [15:0] common_address;
      logic [23:0] object_address;
      logic [2:0]  value_kind;
      logic [31:0] value_bits;
      logic [6:0]  object_count;
      logic        last_of_run;
   } rec_type;

   // Records written into the output queue in one cycle.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // Payload bytes of one information object, zero for unknown types.
   function automatic logic [3:0] payload_size(input logic [7:0] t);
      logic [3:0] s;
      unique case (t)
         8'd1, 8'd3, 8'd20, 8'd45, 8'd46:  s = 4'd1;
         8'd21:                            s = 4'd2;
         8'd5, 8'd9, 8'd11, 8'd48, 8'd49:  s = 4'd3;
         8'd2, 8'd4:                       s = 4'd4;
         8'd7, 8'd13, 8'd15, 8'd50:        s = 4'd5;
         8'd6, 8'd10, 8'd12:               s = 4'd6;
         8'd8, 8'd14, 8'd16, 8'd30, 8'd31: s = 4'd8;
         8'd32, 8'd34, 8'd35:              s = 4'd10;
         8'd33, 8'd36, 8'd37:              s = 4'd12;
         default:                          s = 4'd0;
      endcase
      return s;
   endfunction

   // Value kind carried by each type.
   function automatic logic [2:0] kind_of(input logic [7:0] t);
      logic [2:0] k;
      unique case (t)
         8'd1, 8'd2, 8'd30, 8'd45:                        k = KIND_SINGLE;
         8'd3, 8'd4, 8'd31, 8'd46:                        k = KIND_DOUBLE;
         8'd5, 8'd6, 8'd32, 8'd11, 8'd12, 8'd35, 8'd49:   k = KIND_INT16;
         8'd7, 8'd8, 8'd33, 8'd15, 8'd16, 8'd37:          k = KIND_INT32;
         8'd9, 8'd10, 8'd34, 8'd21, 8'd48:                k = KIND_NORM;
         8'd13, 8'd14, 8'd36, 8'd50:                      k = KIND_FLOAT;
         default:                                         k = KIND_BYTE;
      endcase
      return k;
   endfunction

   // Cut the collected payload word down to the bits of its kind.
   function automatic logic [31:0] extract(input logic [2:0] kind, input logic [31:0] acc);
      logic [31:0] v;
      unique case (kind)
         KIND_SINGLE:           v = {31'd0, acc[0]};
         KIND_DOUBLE:           v = {30'd0, acc[1:0]};
         KIND_INT16, KIND_NORM: v = {{16{acc[15]}}, acc[15:0]};
         KIND_INT32, KIND_FLOAT: v = acc;
         default:               v = {24'd0, acc[7:0]};
      endcase
      return v;
   endfunction

   // Field width registers: zero acts as one, above the maximum acts as the maximum.
   function automatic logic [1:0] clamp_width(input logic [1:0] v, input logic [1:0] hi);
      logic [1:0] w;
      if (v == 2'd0) begin
         w = 2'd1;
      end else if (v > hi) begin
         w = hi;
      end else begin
         w = v;
      end
      return w;
   endfunction

endpackage

// ===== sv/asdu_fifo.sv =====
// Result record queue: takes up to two records per cycle, gives one on out_ready.
// Depends on asdu_pkg and asdu_information_object_decoder_assert.svh.
module asdu_fifo #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  asdu_pkg::push_type push,
   input  asdu_pkg::rec_type  rec0,
   input  asdu_pkg::rec_type  rec1,
   output logic               space_two,
   output logic               out_valid,
   input  logic               out_ready,
   output asdu_pkg::rec_type  out_rec
);
   import asdu_pkg::*;
   `include "asdu_information_object_decoder_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_TWO = CNT_W'(DEPTH - 2);

   rec_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, wr_next, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   assign out_valid = (count_ff != '0);
   assign out_rec   = mem_ff[rd_ff];
   assign space_two = (count_ff <= ROOM_TWO);
   assign pop       = out_valid && out_ready;
   assign wr_next   = ptr_inc(wr_ff);

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push.first && push.second) begin
         wr_in = ptr_inc(wr_next);
      end else if (push.first) begin
         wr_in = wr_next;
      end
      if (pop) begin
         rd_in = ptr_inc(rd_ff);
      end
      count_in = count_ff + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ff] <= rec0;
      end
      if (push.second) begin
         mem_ff[wr_next] <= rec1;
      end
   end

   `ASDU_ASSERT(a_no_overflow, clock, reset, push.first |-> count_ff <= ROOM_TWO)
   `ASDU_ASSERT(a_second_needs_first, clock, reset, push.second |-> push.first)
   `ASDU_ASSERT(a_pop_drains, clock, reset,
      (pop && !push.first) |=> count_ff == $past(count_ff) - 1'b1)
   `ASDU_ASSERT_NR(a_reset_empty, clock, reset |=> count_ff == '0)

endmodule

// ===== sv/asdu_parser.sv =====
// Header and object parser: holds the per-ASDU state and builds records per byte.
// Depends on asdu_pkg and asdu_information_object_decoder_assert.svh.
module asdu_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [1:0]         csr_index,
   input  logic [1:0]         csr_wdata,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_asdu,
   output asdu_pkg::push_type push,
   output asdu_pkg::rec_type  rec0,
   output asdu_pkg::rec_type  rec1
);
   import asdu_pkg::*;
   `include "asdu_information_object_decoder_assert.svh"

   typedef enum logic [2:0] {
      PH_TYPE, PH_VSQ, PH_COT, PH_CA, PH_IOA, PH_PAYLOAD, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in, idx_inc;
   logic [7:0]  type_ff, type_in;
   logic [6:0]  remain_ff, remain_in, remain_dec;
   logic        seq_ff, seq_in;
   logic [5:0]  cause_ff, cause_in;
   logic [15:0] ca_ff, ca_in;
   logic [23:0] addr_ff, addr_in;
   logic [31:0] val_ff, val_in;
   logic [6:0]  emitted_ff, emitted_in;
   logic [1:0]  cot_w_ff, ca_w_ff, ioa_w_ff;
   logic [3:0]  size;
   logic [2:0]  kind;
   logic        obj_fire, bad;
   rec_type     obj_rec, end_rec;

   assign size    = payload_size(type_ff);
   assign kind    = kind_of(type_ff);
   assign idx_inc = idx_ff + 4'd1;

   // Next state and records for the byte on the input.
   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      type_in    = type_ff;
      remain_in  = remain_ff;
      remain_dec = remain_ff;
      seq_in     = seq_ff;
      cause_in   = cause_ff;
      ca_in      = ca_ff;
      addr_in    = addr_ff;
      val_in     = val_ff;
      emitted_in = emitted_ff;
      obj_fire   = 1'b0;
      obj_rec    = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            type_in    = data_byte;
            remain_in  = '0;
            seq_in     = 1'b0;
            cause_in   = '0;
            ca_in      = '0;
            addr_in    = '0;
            val_in     = '0;
            emitted_in = '0;
            idx_in     = '0;
            phase_in   = PH_VSQ;
         end
         PH_VSQ: begin
            remain_in = data_byte[6:0];
            seq_in    = data_byte[7];
            idx_in    = '0;
            phase_in  = PH_COT;
         end
         PH_COT: begin
            if (idx_ff == 4'd0) begin
               cause_in = data_byte[5:0];
            end
            idx_in = idx_inc;
            if (idx_inc >= {2'b00, clamp_width(cot_w_ff, 2'd2)}) begin
               idx_in   = '0;
               phase_in = PH_CA;
            end
         end
         PH_CA: begin
            if (idx_ff == 4'd0) begin
               ca_in[7:0] = ca_ff[7:0] | data_byte;
            end else if (idx_ff == 4'd1) begin
               ca_in[15:8] = ca_ff[15:8] | data_byte;
            end
            idx_in = idx_inc;
            if (idx_inc >= {2'b00, clamp_width(ca_w_ff, 2'd2)}) begin
               idx_in  = '0;
               addr_in = '0;
               val_in  = '0;
               if (size == 4'd0 || remain_ff == 7'd0) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_IOA;
               end
            end
         end
         PH_IOA: begin
            if (idx_ff == 4'd0) begin
               addr_in[7:0] = addr_ff[7:0] | data_byte;
            end else if (idx_ff == 4'd1) begin
               addr_in[15:8] = addr_ff[15:8] | data_byte;
            end else if (idx_ff == 4'd2) begin
               addr_in[23:16] = addr_ff[23:16] | data_byte;
            end
            idx_in = idx_inc;
            if (idx_inc >= {2'b00, clamp_width(ioa_w_ff, 2'd3)}) begin
               idx_in   = '0;
               val_in   = '0;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (idx_ff == 4'd0) begin
               val_in[7:0] = val_ff[7:0] | data_byte;
            end else if (idx_ff == 4'd1) begin
               val_in[15:8] = val_ff[15:8] | data_byte;
            end else if (idx_ff == 4'd2) begin
               val_in[23:16] = val_ff[23:16] | data_byte;
            end else if (idx_ff == 4'd3) begin
               val_in[31:24] = val_ff[31:24] | data_byte;
            end
            idx_in = idx_inc;
            if (idx_inc >= size) begin
               // Object complete: emit it, then go to the next one or skip after the last.
               obj_fire               = 1'b1;
               emitted_in             = emitted_ff + 7'd1;
               obj_rec.status         = ST_OBJECT;
               obj_rec.type_id        = type_ff;
               obj_rec.cause          = cause_ff;
               obj_rec.common_address = ca_ff;
               obj_rec.object_address = addr_ff;
               obj_rec.value_kind     = kind;
               obj_rec.value_bits     = extract(kind, val_in);
               obj_rec.object_count   = emitted_in;
               obj_rec.last_of_run    = !end_of_asdu;
               idx_in                 = '0;
               val_in                 = '0;
               if (remain_ff != 7'd0) begin
                  remain_dec = remain_ff - 7'd1;
               end
               remain_in = remain_dec;
               if (remain_dec == 7'd0) begin
                  phase_in = PH_SKIP;
               end else if (seq_ff) begin
                  addr_in = addr_ff + 24'd1;
               end else begin
                  addr_in  = '0;
                  phase_in = PH_IOA;
               end
            end
         end
         default: begin
         end
      endcase

      // End or error record closes the ASDU.
      bad = (phase_in == PH_VSQ) || (phase_in == PH_COT) || (phase_in == PH_CA) ||
            ((phase_in == PH_IOA) && seq_in);
      end_rec                = '0;
      end_rec.status         = bad ? ST_ERROR : ST_END;
      end_rec.type_id        = type_in;
      end_rec.cause          = cause_in;
      end_rec.common_address = ca_in;
      end_rec.object_count   = emitted_in;
      end_rec.last_of_run    = 1'b1;
      if (end_of_asdu) begin
         phase_in = PH_TYPE;
         idx_in   = '0;
      end
   end

   // Records toward the output queue.
   always_comb begin
      push.first  = accept && (obj_fire || end_of_asdu);
      push.second = accept && obj_fire && end_of_asdu;
      rec0        = obj_fire ? obj_rec : end_rec;
      rec1        = end_rec;
   end

   // Parse state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         idx_ff     <= '0;
         type_ff    <= '0;
         remain_ff  <= '0;
         seq_ff     <= 1'b0;
         cause_ff   <= '0;
         ca_ff      <= '0;
         addr_ff    <= '0;
         val_ff     <= '0;
         emitted_ff <= '0;
         cot_w_ff   <= 2'd2;
         ca_w_ff    <= 2'd2;
         ioa_w_ff   <= 2'd3;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            idx_ff     <= idx_in;
            type_ff    <= type_in;
            remain_ff  <= remain_in;
            seq_ff     <= seq_in;
            cause_ff   <= cause_in;
            ca_ff      <= ca_in;
            addr_ff    <= addr_in;
            val_ff     <= val_in;
            emitted_ff <= emitted_in;
         end
         if (csr_wen) begin
            unique case (csr_index)
               CSR_COT_BYTES: cot_w_ff <= csr_wdata;
               CSR_CA_BYTES:  ca_w_ff  <= csr_wdata;
               CSR_IOA_BYTES: ioa_w_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   `ASDU_ASSERT(a_end_restarts, clock, reset,
      (accept && end_of_asdu) |=> phase_ff == PH_TYPE && idx_ff == 4'd0)
   `ASDU_ASSERT(a_objects_pending, clock, reset,
      (phase_ff == PH_IOA || phase_ff == PH_PAYLOAD) |-> remain_ff != 7'd0)
   `ASDU_ASSERT(a_cot_index, clock, reset, (phase_ff == PH_COT) |-> idx_ff < 4'd2)

endmodule

// ===== sv/asdu_information_object_decoder.sv =====
// ASDU information object decoder (IEC 60870-5-104 style), top level.
// The input channel takes one ASDU byte per word on req_tdata, with req_tlast on
// the final byte. The result channel gives one record per word: object records,
// then one end record (or an error record for a short header or a missing base
// address) per ASDU. rsp_tuser is the record status, rsp_tlast marks the last
// record caused by one input byte.
// A byte is parsed in the cycle it is accepted; its records are registered in the
// output queue and reach the result channel from its head. One byte is taken
// every cycle as long as the four-entry queue has room for two records; a byte
// that closes an object and the ASDU together yields two records, which drain at
// one per cycle while rsp_tready is high. The user must set field widths through
// the csr_ write port only while no ASDU is in flight; the block does not enforce
// this. Reset clears the parser to expect a type byte, empties the output queue
// and restores the field widths to two, two and three bytes. When the receiver
// stalls, records wait in the queue and req_tready drops below two free entries.
// Depends on asdu_pkg, asdu_parser and asdu_fifo.
module asdu_information_object_decoder #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_asdu
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // type_id[7:0], cause[13:8], common_address[29:14], object_address[53:30],
   // value_kind[56:54], value_bits[88:57], object_count[95:89]
   output logic [95:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast    // last_of_run
);
   import asdu_pkg::*;

   push_type push;
   rec_type  rec0, rec1, out_rec;
   logic     space_two, accept;

   assign req_tready = space_two;
   assign accept     = req_tvalid && req_tready;

   asdu_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .data_byte   (req_tdata),
      .end_of_asdu (req_tlast),
      .push        (push),
      .rec0        (rec0),
      .rec1        (rec1)
   );

   asdu_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rec0      (rec0),
      .rec1      (rec1),
      .space_two (space_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   // Pack the record onto the result word.
   assign rsp_tdata = {out_rec.object_count, out_rec.value_bits, out_rec.value_kind,
                       out_rec.object_address, out_rec.common_address, out_rec.cause,
                       out_rec.type_id};
   assign rsp_tuser = out_rec.status;
   assign rsp_tlast = out_rec.last_of_run;

endmodule
